// File: hdl/cts_pkg.sv
// shared constants and types for the comparison transform solver
package cts_pkg;

   localparam int DATA_W = 64;

   typedef enum logic [2:0] {
      CMD_DIRECT  = 3'd0,
      CMD_REVERSE = 3'd1,
      CMD_OFFSET  = 3'd2,
      CMD_FACTOR  = 3'd3,
      CMD_XOR     = 3'd4
   } cmd_type;

   typedef struct packed {
      logic              factor;
      logic              hit;
      logic [DATA_W-1:0] val;
   } side_type;

   localparam int SIDE_W = $bits(side_type);

endpackage

// File: hdl/comparison_transform_solver.sv
// top level of the comparison transform solver
// usage:
//   one request transfer (req_valid high, req_stall low) carries a command, a byte
//   width and five 64-bit values; exactly one response transfer follows, in order,
//   with rsp_hit and rsp_solved_value (zero on a miss)
//   the path runs through an input register, an operand stage, a 64-stage divider
//   for the two observed quotients, a check stage, a second 64-stage divider for the
//   sample quotient and the response register
//   throughput is one transfer per cycle when not stalled; the pipeline length is
//   set by the two bit-per-stage dividers, every command takes the same path
//   reset (synchronous, active high) clears every valid bit, so the pipeline and the
//   response register come out empty
//   while rsp_valid is high and rsp_stall is high the whole pipeline holds and
//   req_stall is raised; the response stays unchanged until it is taken
module comparison_transform_solver (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [2:0]                 req_command,
   input  logic [3:0]                 req_width_bytes,
   input  logic [cts_pkg::DATA_W-1:0] req_first_in,
   input  logic [cts_pkg::DATA_W-1:0] req_first_out,
   input  logic [cts_pkg::DATA_W-1:0] req_second_in,
   input  logic [cts_pkg::DATA_W-1:0] req_second_out,
   input  logic [cts_pkg::DATA_W-1:0] req_sample_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_hit,
   output logic [cts_pkg::DATA_W-1:0] rsp_solved_value
);
   import cts_pkg::*;

   logic en;

   // input register
   logic              s0_valid_ff;
   logic [2:0]        s0_cmd_ff;
   logic [3:0]        s0_w_ff;
   logic [DATA_W-1:0] s0_i1_ff, s0_o1_ff, s0_i2_ff, s0_o2_ff, s0_s_ff;

   // operand stage
   logic              s1_valid_ff;
   logic [DATA_W-1:0] s1_i1_ff, s1_o1_ff, s1_i2_ff, s1_o2_ff;
   side_type          s1_side_ff, s1_side_in;
   logic              s1_nz_ff, s1_nz_in;

   // check stage
   logic              s2_valid_ff;
   logic [DATA_W-1:0] s2_f1_ff;
   side_type          s2_side_ff, s2_side_in;

   logic              rsp_valid_ff;
   logic              rsp_hit_ff, rsp_hit_in;
   logic [DATA_W-1:0] rsp_val_ff, rsp_val_in;

   logic              d1_valid, d2_valid, d3_valid;
   logic [DATA_W-1:0] f1, f2, q3;
   logic [SIDE_W-1:0] d1_side, d3_side;
   logic              d2_nz;
   side_type          d1_s, d3_s;

   logic [DATA_W-1:0] mask, diff1, diff2, pat1, pat2, rev;
   logic [3:0]        nbytes;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff  <= req_valid;
         s1_valid_ff  <= s0_valid_ff;
         s2_valid_ff  <= d1_valid && d2_valid;
         rsp_valid_ff <= d3_valid;
      end
      if (en) begin
         s0_cmd_ff  <= req_command;
         s0_w_ff    <= req_width_bytes;
         s0_i1_ff   <= req_first_in;
         s0_o1_ff   <= req_first_out;
         s0_i2_ff   <= req_second_in;
         s0_o2_ff   <= req_second_out;
         s0_s_ff    <= req_sample_value;
         s1_i1_ff   <= s0_i1_ff;
         s1_o1_ff   <= s0_o1_ff;
         s1_i2_ff   <= s0_i2_ff;
         s1_o2_ff   <= s0_o2_ff;
         s1_side_ff <= s1_side_in;
         s1_nz_ff   <= s1_nz_in;
         s2_f1_ff   <= f1;
         s2_side_ff <= s2_side_in;
         rsp_hit_ff <= rsp_hit_in;
         rsp_val_ff <= rsp_val_in;
      end
   end

   // non-dividing commands resolve here
   always_comb begin
      unique case (s0_w_ff)
         4'd1:       mask = DATA_W'(64'hFF);
         4'd2:       mask = DATA_W'(64'hFFFF);
         4'd3, 4'd4: mask = DATA_W'(64'hFFFF_FFFF);
         default:    mask = '1;
      endcase
      nbytes = (s0_w_ff > 4'd8) ? 4'd8 : s0_w_ff;
      rev = '0;
      for (int j = 0; j < 8; j++) begin
         if (4'(j) < nbytes) begin
            rev[8*j +: 8] = s0_i1_ff[8*(int'(nbytes) - 1 - j) +: 8];
         end
      end
      diff1 = mask & (s0_o1_ff - s0_i1_ff);
      diff2 = mask & (s0_o2_ff - s0_i2_ff);
      pat1  = s0_o1_ff ^ s0_i1_ff;
      pat2  = s0_o2_ff ^ s0_i2_ff;
      s1_nz_in   = (s0_i1_ff != '0) && (s0_i2_ff != '0);
      s1_side_in = '{factor: 1'b0, hit: 1'b0, val: '0};
      case (s0_cmd_ff)
         CMD_DIRECT: begin
            s1_side_in.hit = 1'b1;
            s1_side_in.val = s0_i1_ff;
         end
         CMD_REVERSE: begin
            s1_side_in.hit = 1'b1;
            s1_side_in.val = rev;
         end
         CMD_OFFSET: begin
            if (diff1 != '0 && diff1 == diff2) begin
               s1_side_in.hit = 1'b1;
               s1_side_in.val = s0_s_ff - diff1;
            end
         end
         CMD_FACTOR: begin
            s1_side_in.factor = 1'b1;
            s1_side_in.val    = s0_s_ff;
         end
         CMD_XOR: begin
            if (pat1 != '0 && pat1 == pat2) begin
               s1_side_in.hit = 1'b1;
               s1_side_in.val = s0_s_ff ^ pat1;
            end
         end
         default: s1_side_in.hit = 1'b0;
      endcase
   end

   cts_div #(.WIDTH(DATA_W), .SIDE_W(SIDE_W)) u_div_first (
      .clock    (clock),
      .reset    (reset),
      .enable   (en),
      .in_valid (s1_valid_ff),
      .dividend (s1_o1_ff),
      .divisor  (s1_i1_ff),
      .in_side  (s1_side_ff),
      .out_valid(d1_valid),
      .quotient (f1),
      .out_side (d1_side)
   );

   cts_div #(.WIDTH(DATA_W), .SIDE_W(1)) u_div_second (
      .clock    (clock),
      .reset    (reset),
      .enable   (en),
      .in_valid (s1_valid_ff),
      .dividend (s1_o2_ff),
      .divisor  (s1_i2_ff),
      .in_side  (s1_nz_ff),
      .out_valid(d2_valid),
      .quotient (f2),
      .out_side (d2_nz)
   );

   // factor check
   always_comb begin
      d1_s       = side_type'(d1_side);
      s2_side_in = d1_s;
      if (d1_s.factor) begin
         s2_side_in.hit = d2_nz && (f1 == f2) && (f1 > DATA_W'(1));
      end
   end

   cts_div #(.WIDTH(DATA_W), .SIDE_W(SIDE_W)) u_div_sample (
      .clock    (clock),
      .reset    (reset),
      .enable   (en),
      .in_valid (s2_valid_ff),
      .dividend (s2_side_ff.val),
      .divisor  (s2_f1_ff),
      .in_side  (s2_side_ff),
      .out_valid(d3_valid),
      .quotient (q3),
      .out_side (d3_side)
   );

   always_comb begin
      d3_s       = side_type'(d3_side);
      rsp_hit_in = d3_s.hit;
      if (d3_s.factor) begin
         rsp_val_in = d3_s.hit ? q3 : '0;
      end else begin
         rsp_val_in = d3_s.val;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_solved_value = rsp_val_ff;

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_solved_value == '0)
      else $error("miss with nonzero value");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_solved_value) && $stable(rsp_hit))
      else $error("stalled response changed");

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      d1_valid == d2_valid)
      else $error("quotient dividers out of step");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

// File: hdl/cts_div.sv
// pipelined restoring divider, one quotient bit per stage, sideband travels alongside
module cts_div #(
   parameter int WIDTH  = cts_pkg::DATA_W,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic [WIDTH-1:0]  dividend,
   input  logic [WIDTH-1:0]  divisor,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [WIDTH-1:0]  quotient,
   output logic [SIDE_W-1:0] out_side
);
   import cts_pkg::*;

   for (genvar k = 0; k < WIDTH; k++) begin : g_stage
      logic [WIDTH-1:0]  rem_ff;
      logic [WIDTH-1:0]  dq_ff;
      logic [WIDTH-1:0]  dv_ff;
      logic [SIDE_W-1:0] side_ff;
      logic              vld_ff;
      logic [WIDTH-1:0]  rem_in;
      logic [WIDTH-1:0]  dq_in;
      logic [WIDTH-1:0]  rem_src;
      logic [WIDTH-1:0]  dq_src;
      logic [WIDTH-1:0]  dv_src;
      logic [SIDE_W-1:0] side_src;
      logic              vld_src;
      logic [WIDTH:0]    trial;
      logic              ge;

      if (k == 0) begin : g_first
         assign rem_src  = '0;
         assign dq_src   = dividend;
         assign dv_src   = divisor;
         assign side_src = in_side;
         assign vld_src  = in_valid;
      end else begin : g_next
         assign rem_src  = g_stage[k-1].rem_ff;
         assign dq_src   = g_stage[k-1].dq_ff;
         assign dv_src   = g_stage[k-1].dv_ff;
         assign side_src = g_stage[k-1].side_ff;
         assign vld_src  = g_stage[k-1].vld_ff;
      end

      always_comb begin
         trial  = {rem_src, dq_src[WIDTH-1]};
         ge     = trial >= {1'b0, dv_src};
         rem_in = ge ? WIDTH'(trial - {1'b0, dv_src}) : trial[WIDTH-1:0];
         dq_in  = {dq_src[WIDTH-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (enable) begin
            vld_ff <= vld_src;
         end
         if (enable) begin
            rem_ff  <= rem_in;
            dq_ff   <= dq_in;
            dv_ff   <= dv_src;
            side_ff <= side_src;
         end
      end
   end

   assign out_valid = g_stage[WIDTH-1].vld_ff;
   assign quotient  = g_stage[WIDTH-1].dq_ff;
   assign out_side  = g_stage[WIDTH-1].side_ff;

endmodule

// File: dv/tb_top.sv
// self-checking testbench for the comparison transform solver
module tb_top;
   import cts_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [2:0]  command;
      logic [3:0]  width_bytes;
      logic [63:0] first_in;
      logic [63:0] first_out;
      logic [63:0] second_in;
      logic [63:0] second_out;
      logic [63:0] sample_value;
   } solve_req_type;

   typedef struct {
      logic        hit;
      logic [63:0] solved_value;
   } solve_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_command = '0;
   logic [3:0]  req_width_bytes = '0;
   logic [63:0] req_first_in = '0;
   logic [63:0] req_first_out = '0;
   logic [63:0] req_second_in = '0;
   logic [63:0] req_second_out = '0;
   logic [63:0] req_sample_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_hit;
   logic [63:0] rsp_solved_value;

   solve_req_type pending_reqs[$];
   solve_rsp_type expected_rsps[$];
   int         error_count = 0;
   int         sent_count = 0;
   int         total_reqs = 0;
   int         req_gap = 0;
   int         rsp_gap = 0;
   bit         quiet_phase = 1'b0;
   bit         driving = 1'b0;

   comparison_transform_solver dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [63:0] reverse_low_bytes(logic [63:0] v, logic [3:0] w);
      logic [63:0] r;
      int          n;
      r = '0;
      n = (w > 8) ? 8 : w;
      for (int i = 0; i < n; i++) r[8*(n-1-i) +: 8] = v[8*i +: 8];
      return r;
   endfunction

   function automatic solve_rsp_type solve_relation(solve_req_type q);
      solve_rsp_type r;
      logic [63:0]   m, a, b;
      r.hit = 1'b0;
      r.solved_value = '0;
      case (q.command)
         CMD_DIRECT: begin
            r.hit = 1'b1;
            r.solved_value = q.first_in;
         end
         CMD_REVERSE: begin
            r.hit = 1'b1;
            r.solved_value = reverse_low_bytes(q.first_in, q.width_bytes);
         end
         CMD_OFFSET: begin
            case (q.width_bytes)
               4'd1: m = 64'hFF;
               4'd2: m = 64'hFFFF;
               4'd3, 4'd4: m = 64'hFFFF_FFFF;
               default: m = '1;
            endcase
            a = m & (q.first_out - q.first_in);
            b = m & (q.second_out - q.second_in);
            if (a != 0 && a == b) begin
               r.hit = 1'b1;
               r.solved_value = q.sample_value - a;
            end
         end
         CMD_FACTOR: begin
            if (q.first_in != 0 && q.second_in != 0) begin
               a = q.first_out / q.first_in;
               b = q.second_out / q.second_in;
               if (a > 1 && a == b) begin
                  r.hit = 1'b1;
                  r.solved_value = q.sample_value / a;
               end
            end
         end
         CMD_XOR: begin
            a = q.first_out ^ q.first_in;
            b = q.second_out ^ q.second_in;
            if (a != 0 && a == b) begin
               r.hit = 1'b1;
               r.solved_value = q.sample_value ^ a;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] edge_val();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return 64'd1;
         3: return 64'h8000_0000_0000_0000;
         4: return rand64() >> $urandom_range(0, 63);
         default: return rand64();
      endcase
   endfunction

   function automatic solve_req_type random_req();
      solve_req_type q;
      logic [63:0]   rel;
      q.command = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
      q.width_bytes = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(1, 8));
      q.first_in = edge_val();
      q.first_out = edge_val();
      q.second_in = edge_val();
      q.second_out = edge_val();
      q.sample_value = edge_val();
      if ($urandom_range(0, 3) != 0) begin
         case (q.command)
            CMD_OFFSET: begin
               rel = q.first_out - q.first_in;
               q.second_out = q.second_in + rel;
               if ($urandom_range(0, 2) == 0)
                  q.second_out[63:32] = $urandom();
            end
            CMD_FACTOR: begin
               rel = 64'($urandom_range(0, 300));
               q.first_in = rand64() >> $urandom_range(8, 63);
               q.second_in = rand64() >> $urandom_range(8, 63);
               q.first_out = q.first_in * rel + q.first_in / 2;
               q.second_out = q.second_in * rel + (rand64() % (q.second_in + 1));
               if (q.second_in != 0 && q.second_out / q.second_in != rel)
                  q.second_out = q.second_in * rel;
            end
            CMD_XOR: q.second_out = q.second_in ^ q.first_out ^ q.first_in;
            default: ;
         endcase
      end
      return q;
   endfunction

   task automatic add_req(logic [2:0] c, logic [3:0] w, logic [63:0] i1, logic [63:0] o1,
                          logic [63:0] i2, logic [63:0] o2, logic [63:0] s);
      solve_req_type q;
      q.command = c;
      q.width_bytes = w;
      q.first_in = i1;
      q.first_out = o1;
      q.second_in = i2;
      q.second_out = o2;
      q.sample_value = s;
      pending_reqs.push_back(q);
   endtask

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   initial begin
      add_req(CMD_DIRECT, 4'd8, '1, 0, 0, 0, 0);
      add_req(CMD_DIRECT, 4'd1, '0, 0, 0, 0, 0);
      add_req(CMD_REVERSE, 4'd8, 64'h0123_4567_89AB_CDEF, 0, 0, 0, 0);
      add_req(CMD_REVERSE, 4'd3, 64'h0123_4567_89AB_CDEF, 0, 0, 0, 0);
      add_req(CMD_REVERSE, 4'd0, '1, 0, 0, 0, 0);
      add_req(CMD_REVERSE, 4'd15, 64'h0123_4567_89AB_CDEF, 0, 0, 0, 0);
      add_req(CMD_OFFSET, 4'd1, 10, 15, 100, 105, 7);
      add_req(CMD_OFFSET, 4'd3, 64'hAA_0000_0010, 64'h20, 64'h30, 64'h40, 5);
      add_req(CMD_OFFSET, 4'd8, '1, 0, 5, 6, 0);
      add_req(CMD_OFFSET, 4'd0, 1, 3, 7, 9, 1);
      add_req(CMD_OFFSET, 4'd2, 4, 4, 9, 9, 1);
      add_req(CMD_FACTOR, 4'd8, 3, 12, 5, 20, 100);
      add_req(CMD_FACTOR, 4'd8, 0, 12, 5, 20, 100);
      add_req(CMD_FACTOR, 4'd8, 3, 12, 0, 20, 100);
      add_req(CMD_FACTOR, 4'd8, 3, 5, 4, 7, 100);
      add_req(CMD_FACTOR, 4'd8, 1, '1, 1, '1, '1);
      add_req(CMD_XOR, 4'd8, 64'hF0, 64'h0F, 64'h11, 64'hEE, '1);
      add_req(CMD_XOR, 4'd8, 5, 5, 6, 6, 1);
      add_req(3'd5, 4'd4, 1, 2, 3, 4, 5);
      add_req(3'd7, 4'd8, '1, '1, '1, '1, '1);
      for (int i = 0; i < 2000; i++) pending_reqs.push_back(random_req());
      total_reqs = pending_reqs.size();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      driving = 1'b1;
   end

   // driver
   always @(posedge clock) begin
      if (driving) begin
         if (req_valid && !req_stall) sent_count <= sent_count + 1;
         if (!req_valid || !req_stall) begin
            if (sent_count + (req_valid ? 1 : 0) > total_reqs - 200) quiet_phase <= 1'b1;
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
               req_gap <= $urandom_range(0, 2);
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               solve_req_type q;
               q = pending_reqs.pop_front();
               expected_rsps.push_back(solve_relation(q));
               req_valid <= 1'b1;
               req_command <= q.command;
               req_width_bytes <= q.width_bytes;
               req_first_in <= q.first_in;
               req_first_out <= q.first_out;
               req_second_in <= q.second_in;
               req_second_out <= q.second_out;
               req_sample_value <= q.sample_value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and stall generation
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("response transfer with nothing expected");
            end else begin
               solve_rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp_hit !== e.hit)
                  report_mismatch($sformatf("hit %b expected %b", rsp_hit, e.hit));
               if (rsp_solved_value !== e.solved_value)
                  report_mismatch($sformatf("solved_value %h expected %h",
                                            rsp_solved_value, e.solved_value));
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            rsp_gap <= $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      wait (driving);
      wait (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0);
      repeat (300) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #200us;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
